// ===== rtl/srgb_pixel_colour_temperature_assert.svh =====
// Assertion macros for the sRGB colour temperature pipeline.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef SRGB_PIXEL_COLOUR_TEMPERATURE_ASSERT_SVH
`define SRGB_PIXEL_COLOUR_TEMPERATURE_ASSERT_SVH

// Implication in the same cycle.
`define SCT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("colour temperature pipeline check failed");

// Implication in the next cycle.
`define SCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("colour temperature pipeline check failed");

`endif

// ===== rtl/sct_pkg.sv =====
// Shared types, constants and the sRGB decode table builder for the colour
// temperature pipeline. Used by srgb_pixel_colour_temperature.
package sct_pkg;

  localparam int LIN_MAX_W = 25;
  localparam int CHROMA_W  = 21;
  localparam int SLOPE_W   = 38;
  localparam int H_W       = 61;

  typedef logic [LIN_MAX_W-1:0] lin_tab_t [256];

  typedef struct packed {
    logic v;
    logic black;
    logic steep;
    logic neg;
  } ctl_t;

  localparam logic [13:0] CF_XR = 14'd4124;
  localparam logic [13:0] CF_XG = 14'd3576;
  localparam logic [13:0] CF_XB = 14'd1805;
  localparam logic [13:0] CF_YR = 14'd2126;
  localparam logic [13:0] CF_YG = 14'd7152;
  localparam logic [13:0] CF_YB = 14'd722;
  localparam logic [13:0] CF_ZR = 14'd193;
  localparam logic [13:0] CF_ZG = 14'd1192;
  localparam logic [13:0] CF_ZB = 14'd9505;

  localparam logic [CHROMA_W-1:0] X_KNEE = 21'd348127;
  localparam logic [CHROMA_W-1:0] Y_POLE = 21'd194825;

  localparam logic [15:0] CUBIC_A = 16'd44900;
  localparam logic signed [H_W-1:0] CUBIC_B = 61'sd352500 <<< 32;
  localparam logic signed [H_W-1:0] CUBIC_C = 61'sd682330 <<< 32;
  localparam logic signed [H_W-1:0] CUBIC_D = 61'sd552033 <<< 16;

  localparam logic [31:0] ROUND_100 = 32'd3276800;
  localparam logic [31:0] SAT_Q     = 32'd3355443300;
  localparam logic [31:0] DIV100_M  = 32'd1374389535;
  localparam int          DIV100_SH = 37;

  localparam logic [25:0] T_MAX = 26'h1FFFFFF;
  localparam logic [25:0] T_MIN = 26'h2000000;
  localparam logic [26:0] MAG_MAX = 27'h1FFFFFF;
  localparam logic [26:0] MAG_NEG = 27'h2000000;

  function automatic logic [63:0] fifth_q30(input logic [63:0] r);
    logic [63:0] r2;
    logic [63:0] r4;
    r2 = (r * r) >> 30;
    r4 = (r2 * r2) >> 30;
    return (r4 * r) >> 30;
  endfunction

  function automatic logic [63:0] decode_code(input int c, input int f);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] y;
    if (c <= 10) begin
      return (((64'(c) * 64'd5) << f) + 64'd8236) / 64'd16473;
    end
    u  = (((64'(c) * 64'd1000 + 64'd14025) << 30) + 64'd134512) / 64'd269025;
    u2 = (u * u + (64'd1 << 29)) >> 30;
    lo = 64'd0;
    hi = 64'd1 << 30;
    for (int k = 0; k < 32; k++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (fifth_q30(mid) <= u2) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    y = (u2 * lo + (64'd1 << 29)) >> 30;
    return (y + (64'd1 << (29 - f))) >> (30 - f);
  endfunction

  function automatic lin_tab_t build_table(input int f);
    lin_tab_t t;
    for (int c = 0; c < 256; c++) begin
      t[c] = LIN_MAX_W'(decode_code(c, f));
    end
    return t;
  endfunction

endpackage

// ===== rtl/srgb_pixel_colour_temperature.sv =====
// sRGB pixel to correlated colour temperature (McCamy's cubic), fully pipelined.
// Depends on sct_pkg, sct_div and srgb_pixel_colour_temperature_assert.svh.
//
// One pixel is taken on every clock edge at which start is high; busy is never
// raised, so the source may stream a pixel per cycle without pause. Each pixel
// gives exactly one result, which appears on the out ports once its transaction has
// passed every stage, and stays for a single cycle with out_strobe high;
// the receiver cannot stall and must take it then. The latency is set by the
// bit-per-stage dividers, the 21-stage pair for x and y and chiefly the 38-stage one
// that forms the slope (x - 0.3320)/(0.1858 - y), and by the two split 60x38
// multiplications of the cubic, six stages each. A black pixel returns 0 with
// out_black_pixel set; a result beyond the 26-bit range saturates and sets out_clipped.
module srgb_pixel_colour_temperature #(
  parameter int LIN_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         in_red_level,
  input  logic [7:0]         in_green_level,
  input  logic [7:0]         in_blue_level,
  output logic               out_strobe,
  output logic signed [25:0] out_temperature_q4,
  output logic               out_black_pixel,
  output logic               out_clipped
);

  `include "srgb_pixel_colour_temperature_assert.svh"

  localparam int LW   = LIN_FRAC_BITS + 1;
  localparam int SW   = LIN_FRAC_BITS + 14;
  localparam int TW   = LIN_FRAC_BITS + 15;
  localparam int CW   = sct_pkg::CHROMA_W;
  localparam int NQW  = sct_pkg::SLOPE_W;
  localparam int HW   = sct_pkg::H_W;
  localparam int AW   = HW + OUT_FRAC_BITS;
  localparam int QSW  = AW - 16;

  localparam sct_pkg::lin_tab_t LIN_TAB = sct_pkg::build_table(LIN_FRAC_BITS);

  assign busy = 1'b0;

  // Decode table lookup.
  logic          v1_r;
  logic [LW-1:0] lin_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    lin_r[0] <= LIN_TAB[in_red_level][LW-1:0];
    lin_r[1] <= LIN_TAB[in_green_level][LW-1:0];
    lin_r[2] <= LIN_TAB[in_blue_level][LW-1:0];
  end

  // Matrix to XYZ.
  logic          v2_r;
  logic [SW-1:0] xs_r, ys_r, zs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    xs_r <= SW'(lin_r[0]) * SW'(sct_pkg::CF_XR) + SW'(lin_r[1]) * SW'(sct_pkg::CF_XG)
          + SW'(lin_r[2]) * SW'(sct_pkg::CF_XB);
    ys_r <= SW'(lin_r[0]) * SW'(sct_pkg::CF_YR) + SW'(lin_r[1]) * SW'(sct_pkg::CF_YG)
          + SW'(lin_r[2]) * SW'(sct_pkg::CF_YB);
    zs_r <= SW'(lin_r[0]) * SW'(sct_pkg::CF_ZR) + SW'(lin_r[1]) * SW'(sct_pkg::CF_ZG)
          + SW'(lin_r[2]) * SW'(sct_pkg::CF_ZB);
  end

  // Sum and black detection.
  logic          v3_r;
  logic          black3_r;
  logic [SW-1:0] xs3_r, ys3_r;
  logic [TW-1:0] tot_r;
  logic [TW-1:0] tot_nxt;

  assign tot_nxt = TW'(xs_r) + TW'(ys_r) + TW'(zs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    xs3_r    <= xs_r;
    ys3_r    <= ys_r;
    tot_r    <= tot_nxt;
    black3_r <= (tot_nxt == '0);
  end

  // Chromaticity x and y.
  logic [CW+TW-1:0] num_x, num_y;
  logic             vx, vy, bx, by;
  logic [CW-1:0]    qx, qy;

  assign num_x = ((CW+TW)'(xs3_r) << 20) + (CW+TW)'(tot_r >> 1);
  assign num_y = ((CW+TW)'(ys3_r) << 20) + (CW+TW)'(tot_r >> 1);

  sct_div #(.QW(CW), .DW(TW), .SBW(1)) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_num    (num_x),
    .in_den    (tot_r),
    .in_side   (black3_r),
    .out_valid (vx),
    .out_quo   (qx),
    .out_side  (bx)
  );

  sct_div #(.QW(CW), .DW(TW), .SBW(1)) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_num    (num_y),
    .in_den    (tot_r),
    .in_side   (black3_r),
    .out_valid (vy),
    .out_quo   (qy),
    .out_side  (by)
  );

  // Slope numerator and denominator.
  logic signed [CW:0] nx, dn;
  logic [CW-1:0]      ux_nxt, ud_nxt;
  logic [CW-1:0]      ux_r, ud_r;
  sct_pkg::ctl_t      c4_r;

  assign nx     = $signed({1'b0, qx}) - $signed({1'b0, sct_pkg::X_KNEE});
  assign dn     = $signed({1'b0, sct_pkg::Y_POLE}) - $signed({1'b0, qy});
  assign ux_nxt = nx[CW] ? CW'(-nx) : CW'(nx);
  assign ud_nxt = dn[CW] ? CW'(-dn) : CW'(dn);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c4_r <= '0;
    end else begin
      c4_r.v     <= vx;
      c4_r.black <= bx;
      c4_r.steep <= {6'b0, ux_nxt} >= {ud_nxt, 6'b0};
      c4_r.neg   <= nx[CW] != dn[CW];
    end
  end

  always_ff @(posedge clk) begin
    ux_r <= ux_nxt;
    ud_r <= ud_nxt;
  end

  // Slope magnitude.
  logic [NQW+CW-1:0] num_n;
  logic              vn;
  logic [NQW-1:0]    nm;
  logic [2:0]        sn;

  assign num_n = ((NQW+CW)'(ux_r) << 32) + (NQW+CW)'(ud_r >> 1);

  sct_div #(.QW(NQW), .DW(CW), .SBW(3)) u_div_n (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c4_r.v),
    .in_num    (num_n),
    .in_den    (ud_r),
    .in_side   ({c4_r.black, c4_r.steep, c4_r.neg}),
    .out_valid (vn),
    .out_quo   (nm),
    .out_side  (sn)
  );

  // First Horner step.
  sct_pkg::ctl_t    c5_r, c6_r;
  logic [NQW-1:0]   nm5_r, nm6_r;
  logic [HW-1:0]    p1_r;
  logic signed [HW-1:0] h1_r;
  logic signed [HW-1:0] p1s;

  assign p1s = $signed(p1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c5_r <= '0;
      c6_r <= '0;
    end else begin
      c5_r <= '{v: vn, black: sn[2], steep: sn[1], neg: sn[0]};
      c6_r <= c5_r;
    end
  end

  always_ff @(posedge clk) begin
    nm5_r <= nm;
    p1_r  <= HW'(nm) * HW'(sct_pkg::CUBIC_A);
    nm6_r <= nm5_r;
    h1_r  <= (c5_r.neg ? -p1s : p1s) + sct_pkg::CUBIC_B;
  end

  // Two split multiplications with rounding and offset.
  logic signed [HW-1:0] mh [3];
  sct_pkg::ctl_t        mc [3];
  logic [NQW-1:0]       mn [3];

  assign mh[0] = h1_r;
  assign mc[0] = c6_r;
  assign mn[0] = nm6_r;

  for (genvar m = 0; m < 2; m++) begin : g_mul
    localparam int SH = (m == 0) ? 32 : 48;
    localparam logic signed [HW-1:0] KOFF = (m == 0) ? sct_pkg::CUBIC_C : sct_pkg::CUBIC_D;
    localparam int PW = 2 * (HW - 1) / 2 + NQW;

    sct_pkg::ctl_t  ca_r, cb_r, cc_r, cd_r, ce_r, cf_r;
    logic [NQW-1:0] na_r, nb_r, nc_r, nd_r, ne_r, nf_r;
    logic           sa_r, sb_r, sc_r, sd_r, se_r;
    logic [HW-2:0]  mag_r;
    logic [48:0]    p00_r, p01_r, p10_r, p11_r;
    logic [67:0]    s0_r, s1_r;
    logic [PW-1:0]  prod_r, rnd_r;
    logic signed [HW-1:0] h_r;
    logic signed [HW-1:0] r_val;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ca_r <= '0;
        cb_r <= '0;
        cc_r <= '0;
        cd_r <= '0;
        ce_r <= '0;
        cf_r <= '0;
      end else begin
        ca_r <= mc[m];
        cb_r <= ca_r;
        cc_r <= cb_r;
        cd_r <= cc_r;
        ce_r <= cd_r;
        cf_r <= ce_r;
      end
    end

    assign r_val = $signed(HW'(rnd_r >> SH));

    always_ff @(posedge clk) begin
      mag_r  <= mh[m][HW-1] ? (HW-1)'(-mh[m]) : (HW-1)'(mh[m]);
      sa_r   <= mh[m][HW-1] ^ mc[m].neg;
      na_r   <= mn[m];
      p00_r  <= 49'(mag_r[29:0]) * 49'(na_r[18:0]);
      p01_r  <= 49'(mag_r[29:0]) * 49'(na_r[37:19]);
      p10_r  <= 49'(mag_r[59:30]) * 49'(na_r[18:0]);
      p11_r  <= 49'(mag_r[59:30]) * 49'(na_r[37:19]);
      sb_r   <= sa_r;
      nb_r   <= na_r;
      s0_r   <= 68'(p00_r) + (68'(p01_r) << 19);
      s1_r   <= 68'(p10_r) + (68'(p11_r) << 19);
      sc_r   <= sb_r;
      nc_r   <= nb_r;
      prod_r <= PW'(s0_r) + (PW'(s1_r) << 30);
      sd_r   <= sc_r;
      nd_r   <= nc_r;
      rnd_r  <= prod_r + (PW'(1) << (SH - 1));
      se_r   <= sd_r;
      ne_r   <= nd_r;
      h_r    <= se_r ? KOFF - r_val : KOFF + r_val;
      nf_r   <= ne_r;
    end

    assign mh[m+1] = h_r;
    assign mc[m+1] = cf_r;
    assign mn[m+1] = nf_r;
  end

  // Scale to output units, divide by 100 and saturate.
  sct_pkg::ctl_t    cg_r, ch_r;
  logic             hng_r, hnh_r, big_r;
  logic [QSW-1:0]   q_r;
  logic [63:0]      qm_r;
  logic [HW-2:0]    h3mag;
  logic [AW-1:0]    a_val;
  logic [26:0]      tm;

  assign h3mag = mh[2][HW-1] ? (HW-1)'(-mh[2]) : (HW-1)'(mh[2]);
  assign a_val = (AW'(h3mag) << OUT_FRAC_BITS) + AW'(sct_pkg::ROUND_100);
  assign tm    = 27'(qm_r >> sct_pkg::DIV100_SH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cg_r <= '0;
      ch_r <= '0;
    end else begin
      cg_r <= mc[2];
      ch_r <= cg_r;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= QSW'(a_val >> 16);
    hng_r <= mh[2][HW-1];
    big_r <= q_r >= QSW'(sct_pkg::SAT_Q);
    qm_r  <= 64'(q_r[31:0]) * 64'(sct_pkg::DIV100_M);
    hnh_r <= hng_r;
  end

  logic               out_strobe_r;
  logic signed [25:0] out_temp_r, out_temp_nxt;
  logic               out_black_r, out_black_nxt;
  logic               out_clip_r, out_clip_nxt;

  always_comb begin
    out_temp_nxt  = '0;
    out_black_nxt = 1'b0;
    out_clip_nxt  = 1'b0;
    if (ch_r.black) begin
      out_black_nxt = 1'b1;
    end else if (ch_r.steep) begin
      out_clip_nxt = 1'b1;
      out_temp_nxt = ch_r.neg ? sct_pkg::T_MIN : sct_pkg::T_MAX;
    end else if (hnh_r) begin
      if (big_r || tm > sct_pkg::MAG_NEG) begin
        out_clip_nxt = 1'b1;
        out_temp_nxt = sct_pkg::T_MIN;
      end else begin
        out_temp_nxt = -$signed(26'(tm));
      end
    end else begin
      if (big_r || tm > sct_pkg::MAG_MAX) begin
        out_clip_nxt = 1'b1;
        out_temp_nxt = sct_pkg::T_MAX;
      end else begin
        out_temp_nxt = $signed(26'(tm));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ch_r.v;
    end
  end

  always_ff @(posedge clk) begin
    out_temp_r  <= out_temp_nxt;
    out_black_r <= out_black_nxt;
    out_clip_r  <= out_clip_nxt;
  end

  assign out_strobe         = out_strobe_r;
  assign out_temperature_q4 = out_temp_r;
  assign out_black_pixel    = out_black_r;
  assign out_clipped        = out_clip_r;

  `SCT_ASSERT_SAME(a_div_lockstep, 1'b1, vx == vy)
  `SCT_ASSERT_SAME(a_div_side_match, vx, bx == by)
  `SCT_ASSERT_SAME(a_black_zero, out_strobe && out_black_pixel,
                   !out_clipped && out_temperature_q4 == '0)
  `SCT_ASSERT_SAME(a_clip_extreme, out_strobe && out_clipped,
                   out_temperature_q4 == sct_pkg::T_MAX || out_temperature_q4 == sct_pkg::T_MIN)
  `SCT_ASSERT_NEXT(a_no_result_from_idle, ch_r.v == 1'b0, !out_strobe)

endmodule

// ===== rtl/sct_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a sideband vector alongside; no package dependencies.
module sct_div #(
  parameter int QW  = 21,
  parameter int DW  = 39,
  parameter int SBW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [QW+DW-1:0]  in_num,
  input  logic [DW-1:0]     in_den,
  input  logic [SBW-1:0]    in_side,
  output logic              out_valid,
  output logic [QW-1:0]     out_quo,
  output logic [SBW-1:0]    out_side
);

  logic           vld_r  [QW];
  logic [DW-1:0]  rem_r  [QW];
  logic [QW-1:0]  low_r  [QW];
  logic [QW-1:0]  quo_r  [QW];
  logic [DW-1:0]  den_r  [QW];
  logic [SBW-1:0] side_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic           v_c;
    logic [DW-1:0]  rem_c;
    logic [QW-1:0]  low_c;
    logic [QW-1:0]  quo_c;
    logic [DW-1:0]  den_c;
    logic [SBW-1:0] side_c;
    logic [DW:0]    trial;
    logic           ge;
    logic [DW-1:0]  rem_nxt;

    if (s == 0) begin : g_first
      assign v_c    = in_valid;
      assign rem_c  = in_num[QW+DW-1:QW];
      assign low_c  = in_num[QW-1:0];
      assign quo_c  = '0;
      assign den_c  = in_den;
      assign side_c = in_side;
    end else begin : g_next
      assign v_c    = vld_r[s-1];
      assign rem_c  = rem_r[s-1];
      assign low_c  = low_r[s-1];
      assign quo_c  = quo_r[s-1];
      assign den_c  = den_r[s-1];
      assign side_c = side_r[s-1];
    end

    assign trial   = {rem_c, low_c[QW-1]};
    assign ge      = trial >= {1'b0, den_c};
    assign rem_nxt = ge ? DW'(trial - {1'b0, den_c}) : DW'(trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_nxt;
      low_r[s]  <= {low_c[QW-2:0], 1'b0};
      quo_r[s]  <= {quo_c[QW-2:0], ge};
      den_r[s]  <= den_c;
      side_r[s] <= side_c;
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule
